// ----- sv/psp_pkg.sv -----
// shared types, constants and the priority picker of the pending-signal controller
package psp_pkg;

   // number of signals; bit vectors of the item are 32 bits wide
   localparam int NumSignals = 32;
   localparam int SetWidth = 32;
   localparam int SigWidth = 5;
   localparam int CodeWidth = 2;
   localparam int SenderWidth = 16;
   localparam int InfoWidth = CodeWidth + SenderWidth;
   localparam int InfoDepth = 1 << SigWidth;

   localparam logic [SigWidth-1:0] SigKill = SigWidth'(9);
   localparam logic [SigWidth-1:0] SigStop = SigWidth'(19);

   localparam logic [SetWidth-1:0] Unblockable =
      (SetWidth'(1) << SigKill) | (SetWidth'(1) << SigStop);

   // signals that exist; bit 0 is dropped only when the set is narrower than the vector
   localparam logic [SetWidth-1:0] ValidBits = (NumSignals >= SetWidth) ? '1 :
      (((SetWidth'(1) << NumSignals) - SetWidth'(1)) & ~SetWidth'(1));

   // csr byte address width and register index
   localparam int CsrAddrWidth = 3;
   localparam logic CsrIgnoreSet = 1'b0;

   typedef enum logic [2:0] {
      OP_RAISE   = 3'd0,
      OP_DELIVER = 3'd1,
      OP_TAKE    = 3'd2,
      OP_BLOCK   = 3'd3,
      OP_UNBLOCK = 3'd4,
      OP_SETMASK = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]             opcode;
      logic [SigWidth-1:0]    signal_number;
      logic [SetWidth-1:0]    signal_set;
      logic [CodeWidth-1:0]   info_code;
      logic [SenderWidth-1:0] sender_id;
   } req_data_type;

   typedef struct packed {
      logic                   found;
      logic [SigWidth-1:0]    taken_signal;
      logic [CodeWidth-1:0]   taken_code;
      logic [SenderWidth-1:0] taken_sender;
      logic                   any_deliverable;
      logic [SetWidth-1:0]    old_mask;
   } rsp_data_type;

   // info memory access issued by the control stage
   typedef struct packed {
      logic                  we;
      logic [SigWidth-1:0]   waddr;
      logic [InfoWidth-1:0]  wdata;
      logic                  re;
      logic [SigWidth-1:0]   raddr;
   } ram_req_type;

   // result stage handed to the output side
   typedef struct packed {
      logic                  strobe;
      logic                  found;
      logic [SigWidth-1:0]   sig;
      logic                  any_deliverable;
      logic [SetWidth-1:0]   old_mask;
   } stage_type;

   // kill first, stop second, then the lowest number above zero; 0 when empty
   function automatic logic [SigWidth-1:0] pick(input logic [SetWidth-1:0] s);
      logic [SigWidth-1:0] idx;
      idx = '0;
      for (int i = SetWidth - 1; i >= 1; i--) begin
         if (s[i]) begin
            idx = SigWidth'(i);
         end
      end
      if (s[SigStop]) begin
         idx = SigStop;
      end
      if (s[SigKill]) begin
         idx = SigKill;
      end
      return idx;
   endfunction

endpackage

// ----- sv/psp_ram.sv -----
// generic single-write, single-read memory with registered read data
module psp_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/psp_ctl.sv -----
// pending bits, block mask, priority pick and info memory access
module psp_ctl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  psp_pkg::req_data_type           req,
   input  logic [psp_pkg::SetWidth-1:0]    ignore_set,
   output psp_pkg::ram_req_type            ram_req,
   output psp_pkg::stage_type              stage
);

   logic [psp_pkg::SetWidth-1:0] pending_ff, pending_in;
   logic [psp_pkg::SetWidth-1:0] mask_ff, mask_in;
   psp_pkg::stage_type           stage_ff, stage_in;

   logic [psp_pkg::SetWidth-1:0] set_v;
   logic [psp_pkg::SetWidth-1:0] bit_v;
   logic [psp_pkg::SetWidth-1:0] cand;
   logic [psp_pkg::SigWidth-1:0] pick_sig;
   logic                         take;
   logic                         raise_ok;

   always_comb begin
      set_v = req.signal_set & psp_pkg::ValidBits;
      bit_v = psp_pkg::SetWidth'(1) << req.signal_number;
      raise_ok = (req.signal_number != '0) && ((bit_v & psp_pkg::ValidBits) != '0)
         && ((ignore_set & ~psp_pkg::Unblockable & bit_v) == '0)
         && ((pending_ff & bit_v) == '0);
      pending_in = pending_ff;
      mask_in = mask_ff;
      cand = '0;
      take = 1'b0;
      ram_req = '0;

      case (psp_pkg::op_type'(req.opcode))
         psp_pkg::OP_RAISE: begin
            if (raise_ok) begin
               pending_in = pending_ff | bit_v;
               ram_req.we = accept;
               ram_req.waddr = req.signal_number;
               ram_req.wdata = {req.info_code, req.sender_id};
            end
         end
         psp_pkg::OP_DELIVER: begin
            cand = pending_ff & ~mask_ff;
            take = 1'b1;
         end
         psp_pkg::OP_TAKE: begin
            cand = pending_ff & set_v;
            take = 1'b1;
         end
         psp_pkg::OP_BLOCK:   mask_in = mask_ff | (set_v & ~psp_pkg::Unblockable);
         psp_pkg::OP_UNBLOCK: mask_in = mask_ff & ~set_v;
         psp_pkg::OP_SETMASK: mask_in = set_v & ~psp_pkg::Unblockable;
         default: ;
      endcase

      pick_sig = psp_pkg::pick(cand);
      if (take && (pick_sig != '0)) begin
         pending_in = pending_in & ~(psp_pkg::SetWidth'(1) << pick_sig);
         ram_req.re = accept;
         ram_req.raddr = pick_sig;
      end

      stage_in.strobe = accept;
      stage_in.found = take && (pick_sig != '0);
      stage_in.sig = take ? pick_sig : '0;
      stage_in.any_deliverable = (pending_in & ~mask_in) != '0;
      stage_in.old_mask = mask_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         mask_ff <= '0;
         stage_ff.strobe <= 1'b0;
      end else begin
         stage_ff.strobe <= stage_in.strobe;
         if (accept) begin
            pending_ff <= pending_in;
            mask_ff <= mask_in;
         end
      end
      stage_ff.found <= stage_in.found;
      stage_ff.sig <= stage_in.sig;
      stage_ff.any_deliverable <= stage_in.any_deliverable;
      stage_ff.old_mask <= stage_in.old_mask;
   end

   assign stage = stage_ff;

endmodule

// ----- sv/pending_signal_priority_controller_unit.sv -----
// top level of the pending-signal priority controller
//
// one item per clock: busy stays low, an item accepted on one edge shows its
// result on rsp_data for exactly one cycle with rsp_strobe high, in the cycle
// after, and the next item may be started in that same cycle. the result is
// registered, as is the read of the 32-entry info memory, which holds
// the code and sender stored when each signal became pending; pending bits
// and the block mask live in flip-flops and are updated on the accepting
// edge, so every item sees the effect of the one before it. a raise writes
// the info memory on its accepting edge and a take reads it on its own,
// so the two never meet on one edge and no forwarding is needed. info
// entries are not cleared by reset; an entry is only read while its pending
// bit is set. ignore_set sits at byte address 0 of the csr port; the user
// must write it only while no item is in flight; the block does not enforce it.
module pending_signal_priority_controller_unit (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  psp_pkg::req_data_type             req_data,
   // result channel
   output logic                              rsp_strobe,
   output psp_pkg::rsp_data_type             rsp_data,
   // csr port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [psp_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [psp_pkg::SetWidth-1:0]      csr_pwdata,
   output logic [psp_pkg::SetWidth-1:0]      csr_prdata,
   output logic                              csr_pready
);

   logic [psp_pkg::SetWidth-1:0]  ignore_ff;
   logic                          accept;
   logic                          csr_hit;
   psp_pkg::ram_req_type          ram_req;
   psp_pkg::stage_type            stage;
   logic [psp_pkg::InfoWidth-1:0] info_rdata;

   // never stalls the command side
   assign busy = 1'b0;
   assign accept = start && !busy;

   // csr: one register, word address taken from paddr[2]
   assign csr_pready = 1'b1;
   assign csr_hit = (csr_paddr[2] == psp_pkg::CsrIgnoreSet);

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         ignore_ff <= csr_pwdata;
      end
   end

   assign csr_prdata = csr_hit ? ignore_ff : '0;

   // pending/mask state and pick
   psp_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .ignore_set (ignore_ff),
      .ram_req    (ram_req),
      .stage      (stage)
   );

   // per-signal info store: {code, sender}
   psp_ram #(
      .Width (psp_pkg::InfoWidth),
      .Depth (psp_pkg::InfoDepth)
   ) u_info_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (info_rdata)
   );

   // result beat: info fields only count when something was taken
   always_comb begin
      rsp_strobe = stage.strobe;
      rsp_data.found = stage.found;
      rsp_data.taken_signal = stage.sig;
      rsp_data.taken_code = stage.found ?
         info_rdata[psp_pkg::InfoWidth-1:psp_pkg::SenderWidth] : '0;
      rsp_data.taken_sender = stage.found ? info_rdata[psp_pkg::SenderWidth-1:0] : '0;
      rsp_data.any_deliverable = stage.any_deliverable;
      rsp_data.old_mask = stage.old_mask;
   end

endmodule

// ----- sv/psp_chk.sv -----
// port-level checks of the pending-signal controller, bound to the top level
module psp_chk (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input psp_pkg::rsp_data_type rsp_data
);

   // one result beat for every accepted item, and none otherwise
   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy && !reset))
      else $error("result beat does not match accepted item");

   // nothing taken means all taken fields are zero
   a_empty_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.found) |-> (rsp_data.taken_signal == '0 &&
         rsp_data.taken_code == '0 && rsp_data.taken_sender == '0))
      else $error("taken fields set without a found signal");

   // signal zero is never pending
   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.found) |-> (rsp_data.taken_signal != '0))
      else $error("signal zero reported as taken");

   // kill and stop can never be blocked
   a_unblockable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!rsp_data.old_mask[psp_pkg::SigKill] &&
         !rsp_data.old_mask[psp_pkg::SigStop]))
      else $error("kill or stop found in block mask");

endmodule

bind pending_signal_priority_controller_unit psp_chk u_psp_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
